[src/assert_macros.svh]
// Assertion macros used by the rrts_checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rrts_pkg.sv]
// Shared types and constants of the round-robin thread scheduler.
// No dependencies; used by every module of the block.
package rrts_pkg;

  localparam int MAX_THREADS_DEF = 32;
  localparam int MAX_CPUS_DEF    = 4;

  localparam int TID_W      = 5;
  localparam int CPU_IN_W   = 2;
  localparam int PSTATE_W   = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;
  localparam int CMD_FIFO_DEPTH = 2;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_kind_e;

  typedef enum logic [PSTATE_W-1:0] {
    PST_FREE     = 2'd0,
    PST_SLEEPING = 2'd1,
    PST_READY    = 2'd2
  } pstate_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cmd_kind_e             kind;
    logic [TID_W-1:0]      tid;
    logic [CPU_IN_W-1:0]   cpu;      // already wrapped below the CPU count
    logic                  add_err;
    pstate_e               pstate;
  } cmd_t;

endpackage

[src/rrts_front.sv]
// Front end: unpacks an input request and classifies it into a command.
// Depends on rrts_pkg.
module rrts_front #(
  parameter int MaxThreads = rrts_pkg::MAX_THREADS_DEF,
  parameter int MaxCpus    = rrts_pkg::MAX_CPUS_DEF
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rrts_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output rrts_pkg::cmd_t                 cmd_o
);

  localparam int WrapSteps = (1 << rrts_pkg::CPU_IN_W) - 1;

  logic [rrts_pkg::TID_W-1:0]    tid;
  logic [rrts_pkg::CPU_IN_W-1:0] cpu_in;
  logic                          dying;
  logic                          wants_sleep;
  logic [31:0]                   cpu_w;

  assign tid         = s_axis_tdata[4:0];
  assign cpu_in      = s_axis_tdata[6:5];
  assign dying       = s_axis_tdata[7];
  assign wants_sleep = s_axis_tdata[8];

  assign s_axis_tready = !fifo_full_i;
  assign push_o        = s_axis_tvalid && !fifo_full_i;

  // Wrap the CPU id below the CPU count by repeated subtraction.
  always_comb begin
    cpu_w = 32'(cpu_in);
    for (int i = 0; i < WrapSteps; i++) begin
      if (cpu_w >= 32'(MaxCpus)) begin
        cpu_w = cpu_w - 32'(MaxCpus);
      end
    end
  end

  always_comb begin
    cmd_o.kind    = rrts_pkg::cmd_kind_e'(s_axis_tuser);
    cmd_o.tid     = tid;
    cmd_o.cpu     = cpu_w[rrts_pkg::CPU_IN_W-1:0];
    cmd_o.add_err = (tid == '0) || (32'(tid) >= 32'(MaxThreads));
    if (s_axis_tuser == rrts_pkg::CMD_ADD) begin
      cmd_o.pstate = rrts_pkg::PST_FREE;
    end else if (dying) begin
      cmd_o.pstate = rrts_pkg::PST_FREE;
    end else if (wants_sleep) begin
      cmd_o.pstate = rrts_pkg::PST_SLEEPING;
    end else begin
      cmd_o.pstate = rrts_pkg::PST_READY;
    end
  end

endmodule

[src/rrts_cmd_fifo.sv]
// Short command queue between the front and the back.
// Depends on rrts_pkg.
module rrts_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rrts_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rrts_pkg::cmd_t data_o
);

  localparam int Depth = rrts_pkg::CMD_FIFO_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  rrts_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/rrts_back.sv]
// Back end: ready queue (link memory, head, tail), per-CPU current thread
// table and the result register. Depends on rrts_pkg.
module rrts_back #(
  parameter int MaxThreads = rrts_pkg::MAX_THREADS_DEF,
  parameter int MaxCpus    = rrts_pkg::MAX_CPUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  rrts_pkg::cmd_t                 cmd_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  localparam int LinkW = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int CpuW  = (MaxCpus > 1) ? $clog2(MaxCpus) : 1;
  localparam int ResW  = 3 * rrts_pkg::TID_W - rrts_pkg::TID_W + rrts_pkg::PSTATE_W + 1;
  localparam int PadW  = rrts_pkg::M_TDATA_W - ResW;

  typedef logic [rrts_pkg::TID_W-1:0] tid_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  function automatic logic [rrts_pkg::M_TDATA_W-1:0] pack_result(
    input tid_t              nxt,
    input tid_t              prev,
    input rrts_pkg::pstate_e pst,
    input logic              err
  );
    return {{PadW{1'b0}}, err, pst, prev, nxt};
  endfunction

  state_e                          state_q, state_d;
  tid_t                            head_q, head_d;
  tid_t                            tail_q, tail_d;
  logic                            empty_q, empty_d;
  logic [MaxCpus-1:0]              cur_vld_q, cur_vld_d;
  rrts_pkg::cmd_t                  cmd_q, cmd_d;
  logic                            out_vld_q, out_vld_d;
  logic [rrts_pkg::M_TDATA_W-1:0]  out_data_q, out_data_d;

  tid_t                            link_mem [MaxThreads];
  tid_t                            cur_mem  [MaxCpus];
  tid_t                            link_rd_q;
  tid_t                            cur_rd_q;

  logic                            lw_en;
  logic [LinkW-1:0]                lw_addr;
  tid_t                            lw_data;
  logic                            lr_en;
  logic                            cw_en;
  logic                            cr_en;
  logic [CpuW-1:0]                 cpu_new;
  logic [CpuW-1:0]                 cpu_cur;

  tid_t                            prev;
  tid_t                            nxt;
  logic                            requeue;
  logic                            out_free;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign cpu_new       = CpuW'(cmd_i.cpu);
  assign cpu_cur       = CpuW'(cmd_q.cpu);
  assign prev          = cur_vld_q[cpu_cur] ? cur_rd_q : '0;
  assign requeue       = (cmd_q.pstate == rrts_pkg::PST_READY) && (prev != '0);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    cur_vld_d  = cur_vld_q;
    cmd_d      = cmd_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    pop_o      = 1'b0;
    lw_en      = 1'b0;
    lw_addr    = LinkW'(tail_q);
    lw_data    = '0;
    lr_en      = 1'b0;
    cw_en      = 1'b0;
    cr_en      = 1'b0;
    nxt        = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop_o = 1'b1;
          if (cmd_i.kind == rrts_pkg::CMD_ADD) begin
            // Append at the tail unless the add is rejected.
            if (!cmd_i.add_err) begin
              if (empty_q) begin
                head_d  = cmd_i.tid;
                empty_d = 1'b0;
              end else begin
                lw_en   = 1'b1;
                lw_data = cmd_i.tid;
              end
              tail_d = cmd_i.tid;
            end
            out_vld_d  = 1'b1;
            out_data_d = pack_result(cmd_i.tid, '0, rrts_pkg::PST_FREE, cmd_i.add_err);
          end else begin
            // Fetch the CPU's current thread and the head's successor.
            cmd_d   = cmd_i;
            cr_en   = 1'b1;
            lr_en   = 1'b1;
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        // Requeue the outgoing thread first.
        if (requeue) begin
          if (empty_q) begin
            head_d  = prev;
            empty_d = 1'b0;
          end else begin
            lw_en   = 1'b1;
            lw_data = prev;
          end
          tail_d = prev;
        end
        // Then dequeue the head; forward the link just written when the
        // head was the old tail.
        if (!empty_d) begin
          nxt = head_d;
          if (head_d == tail_d) begin
            empty_d = 1'b1;
          end else if (requeue && !empty_q && (head_q == tail_q)) begin
            head_d = prev;
          end else begin
            head_d = link_rd_q;
          end
        end
        cw_en              = 1'b1;
        cur_vld_d[cpu_cur] = 1'b1;
        out_vld_d          = 1'b1;
        out_data_d         = pack_result(nxt, prev, cmd_q.pstate, 1'b0);
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      empty_q    <= 1'b1;
      cur_vld_q  <= '0;
      cmd_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      empty_q    <= empty_d;
      cur_vld_q  <= cur_vld_d;
      cmd_q      <= cmd_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (lr_en) begin
      link_rd_q <= link_mem[LinkW'(head_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      cur_mem[cpu_cur] <= nxt;
    end
    if (cr_en) begin
      cur_rd_q <= cur_mem[cpu_new];
    end
  end

endmodule

[src/round_robin_thread_scheduler_unit.sv]
// Channel   Dir  tdata fields (low bit up)                            tuser
// s_axis    in   thread_id[4:0] cpu_id[6:5] dying[7] wants_sleep[8]   action
// m_axis    out  next[4:0] previous[9:5] prev_state[11:10] add_err[12] -
//
// An add completes in the idle state; a schedule needs the execute state,
// too, set by the registered reads of the current-thread table and link memory.
// Each request passes through the command queue and the result register.
// Reset clears head, tail and per-CPU valid bits and sets the empty flag at once.
// A two-entry command queue keeps accepting, until it is full, while the result register waits.
module round_robin_thread_scheduler_unit #(
  parameter int MaxThreads = rrts_pkg::MAX_THREADS_DEF,
  parameter int MaxCpus    = rrts_pkg::MAX_CPUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // thread_id, cpu_id, current_dying, current_wants_sleep, zero pad
  input  logic [rrts_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // next_thread, previous_thread, previous_new_state, add_error, zero pad
  output logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic           push;
  logic           fifo_full;
  logic           fifo_valid;
  logic           pop;
  rrts_pkg::cmd_t cmd_in;
  rrts_pkg::cmd_t cmd_out;

  rrts_front #(
    .MaxThreads(MaxThreads),
    .MaxCpus   (MaxCpus)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  rrts_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (fifo_full),
    .pop_i  (pop),
    .valid_o(fifo_valid),
    .data_o (cmd_out)
  );

  rrts_back #(
    .MaxThreads(MaxThreads),
    .MaxCpus   (MaxCpus)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (fifo_valid),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

[src/rrts_checker.sv]
// Port-level checks of the scheduler's result stream, bound to the top level.
// Depends on rrts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // A rejected add carries no outgoing thread.
  `ASSERT_IMP(a_err_no_prev, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[12],
              (m_axis_tdata[9:5] == '0) && (m_axis_tdata[11:10] == rrts_pkg::PST_FREE),
              "add error with outgoing thread")
  `ASSERT_IMP(a_pstate_code, clk_i, rst_ni, m_axis_tvalid,
              m_axis_tdata[11:10] <= rrts_pkg::PST_READY, "bad outgoing state code")
  `ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid,
              m_axis_tdata[15:13] == '0, "nonzero result padding")
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind round_robin_thread_scheduler_unit rrts_checker u_rrts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[sim/thread_schedule_checker.sv]
// Checker for the round-robin thread scheduler: watches both stream channels,
// predicts each result from its own copy of the ready queue and CPU table.
// Depends on rrts_pkg for the command, state and width definitions.
module thread_schedule_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o,
  output int unsigned sched_count_o,
  output int unsigned reject_count_o,
  output int unsigned idle_grant_count_o
);
  import rrts_pkg::*;

  localparam int MaxThreads = MAX_THREADS_DEF;
  localparam int MaxCpus    = MAX_CPUS_DEF;

  // Packed from the top field down, so it lines up with m_axis_tdata[12:0].
  typedef struct packed {
    logic             add_err;
    pstate_e          prev_state;
    logic [TID_W-1:0] prev_tid;
    logic [TID_W-1:0] next_tid;
  } sched_result_t;

  logic [TID_W-1:0] link_mem [MaxThreads];
  logic [TID_W-1:0] cur_thread [MaxCpus];
  logic [TID_W-1:0] ready_head;
  logic [TID_W-1:0] ready_tail;
  logic             ready_empty;
  sched_result_t    result_q [$];

  task automatic append_ready(input logic [TID_W-1:0] tid);
    if (ready_empty) begin
      ready_head  = tid;
      ready_tail  = tid;
      ready_empty = 1'b0;
    end else begin
      link_mem[ready_tail] = tid;
      ready_tail           = tid;
    end
  endtask

  task automatic take_ready(output logic [TID_W-1:0] tid);
    if (ready_empty) begin
      tid = '0;
    end else begin
      tid = ready_head;
      if (ready_head == ready_tail) begin
        ready_empty = 1'b1;
      end else begin
        ready_head = link_mem[ready_head];
      end
    end
  endtask

  task automatic predict_schedule(input logic [15:0] data, input logic user);
    cmd_kind_e        kind;
    logic [TID_W-1:0] tid;
    int               cpu;
    sched_result_t    res;
    kind = cmd_kind_e'(user);
    tid  = data[4:0];
    cpu  = int'(data[6:5]) % MaxCpus;
    res  = '0;
    res.prev_state = PST_FREE;
    if (kind == CMD_ADD) begin
      res.next_tid = tid;
      res.add_err  = (tid == '0) || (int'(tid) >= MaxThreads);
      if (res.add_err) begin
        reject_count_o++;
      end else begin
        append_ready(tid);
      end
    end else begin
      res.prev_tid = cur_thread[cpu];
      if (data[7]) begin
        res.prev_state = PST_FREE;
      end else if (data[8]) begin
        res.prev_state = PST_SLEEPING;
      end else begin
        res.prev_state = PST_READY;
        // idle thread is reported as ready but never queued
        if (res.prev_tid != '0) append_ready(res.prev_tid);
      end
      take_ready(res.next_tid);
      cur_thread[cpu] = res.next_tid;
      sched_count_o++;
      if (res.next_tid == '0) idle_grant_count_o++;
    end
    result_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    sched_result_t got;
    sched_result_t want;
    if (!rst_ni) begin
      foreach (cur_thread[i]) cur_thread[i] = '0;
      ready_head         = '0;
      ready_tail         = '0;
      ready_empty        = 1'b1;
      result_q.delete();
      mismatch_count_o   = 0;
      pending_o          = 0;
      sched_count_o      = 0;
      reject_count_o     = 0;
      idle_grant_count_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_schedule(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        got = sched_result_t'(m_axis_tdata[12:0]);
        if (result_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("[%0t] result with no request pending: tdata %h", $realtime,
                     m_axis_tdata);
          end
        end else begin
          want = result_q.pop_front();
          if (got.next_tid !== want.next_tid || got.prev_tid !== want.prev_tid ||
              got.prev_state !== want.prev_state || got.add_err !== want.add_err) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("[%0t] mismatch (expected/actual): next %0d/%0d prev %0d/%0d",
                       $realtime, want.next_tid, got.next_tid, want.prev_tid, got.prev_tid);
              $display("         state %0d/%0d add_err %0d/%0d",
                       want.prev_state, got.prev_state, want.add_err, got.add_err);
            end
          end
        end
      end
      pending_o = result_q.size();
    end
  end

endmodule

[sim/round_robin_thread_scheduler_unit_test.sv]
// Testbench top for the round-robin thread scheduler: drives add and schedule
// requests with random gaps and stalls, and gives the verdict.
// Depends on rrts_pkg, round_robin_thread_scheduler_unit and thread_schedule_checker.
module round_robin_thread_scheduler_unit_test;
  import rrts_pkg::*;

  localparam int RandomItems = 1080;
  localparam int StallLimit  = 2000;
  localparam int HoldStart   = 600;
  localparam int HoldCycles  = 250;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // thread_id[4:0] cpu_id[6:5] dying[7] wants_sleep[8] zero[15:9]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // action
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // next[4:0] previous[9:5] prev_state[11:10] add_err[12] zero[15:13]
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sched_count;
  int unsigned reject_count;
  int unsigned idle_grants;
  int unsigned sent_count;

  round_robin_thread_scheduler_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  thread_schedule_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .sched_count_o     (sched_count),
    .reject_count_o    (reject_count),
    .idle_grant_count_o(idle_grants)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request, after random idle cycles when may_idle is set, and hold it until accepted.
  task automatic offer_request(input cmd_kind_e kind, input logic [TID_W-1:0] tid,
                               input logic [1:0] cpu, input logic dying,
                               input logic sleep, input bit may_idle);
    while (may_idle && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'b0, sleep, dying, cpu, tid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  // Receiver: random stalls, one long hold-off, one stretch always ready.
  initial begin : result_sink
    int unsigned rx_cycle;
    rx_cycle      = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldCycles) begin
        m_axis_tready <= 1'b0;
      end else if (rx_cycle >= 1600 && rx_cycle < 2400) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    wait (rst_ni);
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("[%0t] no request or result moved for %0d cycles", $realtime, StallLimit);
    $display("FAIL round_robin_thread_scheduler_unit");
    $finish;
  end

  initial begin : stimulus
    int unsigned add_pct;
    cmd_kind_e   kind;
    logic [TID_W-1:0] tid;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    sent_count    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle thread rejected, idle outgoing as ready on an empty queue
    offer_request(CMD_ADD,   5'd0,  2'd0, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd0, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_ADD,   5'd31, 2'd3, 1'b1, 1'b1, 1'b1);
    offer_request(CMD_ADD,   5'd1,  2'd0, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_ADD,   5'd17, 2'd0, 1'b0, 1'b0, 1'b1);
    // same thread queued twice
    offer_request(CMD_ADD,   5'd17, 2'd0, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd0, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd1, 1'b1, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd2, 1'b0, 1'b1, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd3, 1'b1, 1'b1, 1'b1);
    // requeue a running thread, then let dying beat sleeping
    offer_request(CMD_SCHED, 5'd0,  2'd0, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd1, 1'b1, 1'b1, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd2, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd3, 1'b0, 1'b0, 1'b1);
    offer_request(CMD_ADD,   5'd0,  2'd3, 1'b1, 1'b1, 1'b1);
    offer_request(CMD_SCHED, 5'd31, 2'd0, 1'b1, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd1, 1'b0, 1'b1, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd2, 1'b1, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd3, 1'b1, 1'b0, 1'b1);
    offer_request(CMD_SCHED, 5'd0,  2'd3, 1'b0, 1'b0, 1'b1);

    for (int i = 0; i < RandomItems; i++) begin
      // alternate between filling and draining the ready queue
      add_pct = ((i / 100) % 2 == 0) ? 60 : 30;
      kind    = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_SCHED;
      tid     = ($urandom_range(99) < 5) ? 5'd0 : TID_W'($urandom_range(31, 1));
      offer_request(kind, tid, 2'($urandom_range(3)), $urandom_range(99) < 25,
                    $urandom_range(99) < 30, !(i >= 500 && i < 750));
    end
    s_axis_tvalid <= 1'b0;

    // let the checker record the last request before polling its pending count
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests: %0d schedules (%0d gave the idle thread), %0d rejected adds,",
             sent_count, sched_count, idle_grants, reject_count);
    $display("with random gaps on both sides and one %0d-cycle result hold-off.", HoldCycles);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS round_robin_thread_scheduler_unit");
    end else begin
      $display("FAIL round_robin_thread_scheduler_unit");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/rrts_pkg.sv
src/rrts_front.sv
src/rrts_cmd_fifo.sv
src/rrts_back.sv
src/round_robin_thread_scheduler_unit.sv
src/rrts_checker.sv
sim/thread_schedule_checker.sv
sim/round_robin_thread_scheduler_unit_test.sv
